### rtl/rms_pkg.sv
// Shared types and constants for the rate-monotonic task scheduler.
// No dependencies; every other file imports this package.
`default_nettype none
package rms_pkg;

   localparam int MAX_TASKS  = 16;
   localparam int TIME_WIDTH = 32;
   localparam int SLOT_W     = $clog2(MAX_TASKS);
   localparam int PID_W      = 22;
   localparam int MS_W       = 16;
   localparam int TERM_W     = 10;
   localparam int UTIL_W     = 14;
   localparam int LIMIT_W    = 10;
   localparam int DIVIDEND_W = 26;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [SLOT_W-1:0]     LAST_SLOT   = SLOT_W'(MAX_TASKS - 1);
   localparam logic [TERM_W-1:0]     TERM_MAX    = 10'd1023;
   localparam logic [LIMIT_W-1:0]    LIMIT_RESET = 10'd693;
   localparam logic [TERM_W-1:0]     PERMILLE    = 10'd1000;

   typedef enum logic [1:0] {
      REQ_REGISTER   = 2'd0,
      REQ_YIELD      = 2'd1,
      REQ_DEREGISTER = 2'd2,
      REQ_TICK       = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      RS_OK       = 3'd0,
      RS_REJECT   = 3'd1,
      RS_NOTFOUND = 3'd2,
      RS_MISSED   = 3'd3,
      RS_FULL     = 3'd4
   } rsp_status_type;

   typedef enum logic [1:0] {
      ST_SLEEP = 2'd0,
      ST_RUN   = 2'd1,
      ST_READY = 2'd2
   } run_state_type;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [PID_W-1:0] pid;
      logic [MS_W-1:0]  period_ms;
      logic [MS_W-1:0]  comp_ms;
   } req_item_type;

   typedef struct packed {
      logic [2:0]        status;
      logic              running_valid;
      logic [PID_W-1:0]  running_pid;
      logic [UTIL_W-1:0] utilization_sum;
   } rsp_item_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_DIV,
      S_REG_FIN,
      S_SCAN_Y,
      S_YIELD_APPLY,
      S_SCAN_D,
      S_SCAN_T,
      S_SCAN_DISP,
      S_DISP_APPLY,
      S_DONE
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV_START,
      OP_REG_FINISH,
      OP_YIELD_SCAN,
      OP_YIELD_APPLY,
      OP_DEREG_SCAN,
      OP_TICK_SCAN,
      OP_DISP_SCAN,
      OP_DISP_APPLY,
      OP_RESPOND
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         period_zero;
      logic         div_done;
      logic         scan_last;
      logic         yield_hit;
      logic         any_fired;
      logic         rsp_free;
   } dp_status_type;

endpackage
`default_nettype wire

### rtl/rate_monotonic_task_scheduler.sv
// A register request runs the 26-step divider unless its period is zero; a yield
// runs a dispatch scan unless its pid is unknown; a tick runs one only on a wakeup;
// a deregister does a single table scan. Every table walk visits one slot per cycle.
// One item at a time; the next item is accepted in the cycle after the result is
// registered.
// Reset: synchronous; table empty, time zero, limit 693, ready right after reset.
// Depends on rms_pkg, rms_ctrl and rms_datapath.
`default_nettype none
module rate_monotonic_task_scheduler
   import rms_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_item_type       req_item,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_item_type            rsp_item,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [LIMIT_W-1:0] csr_wdata
);

   ctrl_cmd_type  dp_cmd;
   dp_status_type dp_status;

   rms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   rms_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

endmodule
`default_nettype wire

### rtl/rms_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rms_pkg.
`default_nettype none
module rms_div
   import rms_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [MS_W-1:0]       divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic [MS_W:0]         rem_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [MS_W-1:0]       dvs_ff;
   logic [MS_W:0]         rem_sh;
   logic                  qbit;
   logic [MS_W:0]         rem_in;

   always_comb begin
      rem_sh = {rem_ff[MS_W-1:0], quo_ff[DIVIDEND_W-1]};
      qbit   = rem_sh >= {1'b0, dvs_ff};
      rem_in = qbit ? rem_sh - {1'b0, dvs_ff} : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], qbit};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

### rtl/rms_ctrl.sv
// Sequencer for the scheduler: walks each request through its divide and scan steps.
// Depends on rms_pkg.
`default_nettype none
module rms_ctrl
   import rms_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire dp_status_type dp_status,
   output ctrl_cmd_type       dp_cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      dp_cmd.op = OP_NONE;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               dp_cmd.op = OP_LOAD;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            case (dp_status.kind)
               REQ_REGISTER: begin
                  if (dp_status.period_zero) begin
                     state_in = S_DONE;
                  end else begin
                     dp_cmd.op = OP_DIV_START;
                     state_in  = S_DIV;
                  end
               end
               REQ_YIELD:      state_in = S_SCAN_Y;
               REQ_DEREGISTER: state_in = S_SCAN_D;
               default:        state_in = S_SCAN_T;
            endcase
         end
         S_DIV: begin
            if (dp_status.div_done) begin
               state_in = S_REG_FIN;
            end
         end
         S_REG_FIN: begin
            dp_cmd.op = OP_REG_FINISH;
            state_in  = S_DONE;
         end
         S_SCAN_Y: begin
            dp_cmd.op = OP_YIELD_SCAN;
            if (dp_status.scan_last) begin
               state_in = S_YIELD_APPLY;
            end
         end
         S_YIELD_APPLY: begin
            dp_cmd.op = OP_YIELD_APPLY;
            state_in  = dp_status.yield_hit ? S_SCAN_DISP : S_DONE;
         end
         S_SCAN_D: begin
            dp_cmd.op = OP_DEREG_SCAN;
            if (dp_status.scan_last) begin
               state_in = S_DONE;
            end
         end
         S_SCAN_T: begin
            dp_cmd.op = OP_TICK_SCAN;
            if (dp_status.scan_last) begin
               state_in = dp_status.any_fired ? S_SCAN_DISP : S_DONE;
            end
         end
         S_SCAN_DISP: begin
            dp_cmd.op = OP_DISP_SCAN;
            if (dp_status.scan_last) begin
               state_in = S_DISP_APPLY;
            end
         end
         S_DISP_APPLY: begin
            dp_cmd.op = OP_DISP_APPLY;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (dp_status.rsp_free) begin
               dp_cmd.op = OP_RESPOND;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

### rtl/rms_datapath.sv
// Task table, time base, utilization sum, divider and result register.
// Depends on rms_pkg and rms_div.
`default_nettype none
module rms_datapath
   import rms_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire req_item_type       req_item,
   input  wire ctrl_cmd_type       dp_cmd,
   output dp_status_type           dp_status,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_item_type            rsp_item,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [LIMIT_W-1:0] csr_wdata
);

   logic [MAX_TASKS-1:0]  valid_ff;
   logic [MAX_TASKS-1:0]  armed_ff;
   logic [PID_W-1:0]      pid_ff    [MAX_TASKS];
   logic [MS_W-1:0]       period_ff [MAX_TASKS];
   logic [TERM_W-1:0]     term_ff   [MAX_TASKS];
   run_state_type         rs_ff     [MAX_TASKS];
   logic [TIME_WIDTH-1:0] last_ff   [MAX_TASKS];
   logic [TIME_WIDTH-1:0] wake_ff   [MAX_TASKS];

   req_item_type          req_ff;
   logic                  grant_valid_ff;
   logic [SLOT_W-1:0]     grant_slot_ff;
   logic [TIME_WIDTH-1:0] now_ff;
   logic [UTIL_W-1:0]     util_ff;
   logic [LIMIT_W-1:0]    limit_ff;
   logic [SLOT_W-1:0]     idx_ff;
   logic                  yfound_ff;
   logic [SLOT_W-1:0]     yidx_ff;
   logic                  hit_ff;
   logic                  fired_ff;
   logic                  dfound_ff;
   logic [SLOT_W-1:0]     best_ff;
   logic [MS_W-1:0]       best_period_ff;
   rsp_status_type        status_ff;
   logic                  rsp_valid_ff;
   rsp_item_type          rsp_item_ff;

   logic                  div_done;
   logic [DIVIDEND_W-1:0] quotient;
   logic [DIVIDEND_W-1:0] dividend;
   logic [TERM_W-1:0]     term;
   logic [UTIL_W:0]       sum_new;
   logic                  over_limit;
   logic                  free_found;
   logic [SLOT_W-1:0]     free_idx;
   logic                  cur_match;
   logic                  fire_now;
   logic                  cand;
   logic                  scan_last;
   logic [TIME_WIDTH-1:0] next_time;
   logic [TIME_WIDTH-1:0] diff;
   logic                  missed;
   logic                  rsp_free;
   logic                  reg_ok;

   rms_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dp_cmd.op == OP_DIV_START),
      .dividend (dividend),
      .divisor  (req_ff.period_ms),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      dividend   = DIVIDEND_W'(req_ff.comp_ms) * DIVIDEND_W'(PERMILLE);
      term       = (quotient > DIVIDEND_W'(TERM_MAX)) ? TERM_MAX : quotient[TERM_W-1:0];
      sum_new    = {1'b0, util_ff} + (UTIL_W+1)'(term);
      over_limit = sum_new > (UTIL_W+1)'(limit_ff);
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = MAX_TASKS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
      reg_ok    = !over_limit && free_found;
      scan_last = idx_ff == LAST_SLOT;
      cur_match = valid_ff[idx_ff] && (pid_ff[idx_ff] == req_ff.pid);
      fire_now  = valid_ff[idx_ff] && armed_ff[idx_ff] && (wake_ff[idx_ff] == now_ff);
      cand      = valid_ff[idx_ff] && (rs_ff[idx_ff] == ST_READY || rs_ff[idx_ff] == ST_RUN)
                  && (!dfound_ff || period_ff[idx_ff] < best_period_ff);
      next_time = last_ff[yidx_ff] + TIME_WIDTH'(period_ff[yidx_ff]);
      diff      = now_ff - next_time;
      missed    = !diff[TIME_WIDTH-1];
      rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      dp_status.kind        = req_kind_type'(req_ff.req_type);
      dp_status.period_zero = req_ff.period_ms == '0;
      dp_status.div_done    = div_done;
      dp_status.scan_last   = scan_last;
      dp_status.yield_hit   = yfound_ff;
      dp_status.any_fired   = fired_ff || fire_now;
      dp_status.rsp_free    = rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         armed_ff       <= '0;
         grant_valid_ff <= 1'b0;
         grant_slot_ff  <= '0;
         now_ff         <= '0;
         util_ff        <= '0;
         limit_ff       <= LIMIT_RESET;
         idx_ff         <= '0;
         yfound_ff      <= 1'b0;
         hit_ff         <= 1'b0;
         fired_ff       <= 1'b0;
         dfound_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_wdata;
         end
         if (rsp_valid_ff && !rsp_stall && dp_cmd.op != OP_RESPOND) begin
            rsp_valid_ff <= 1'b0;
         end
         case (dp_cmd.op)
            OP_LOAD: begin
               idx_ff    <= '0;
               yfound_ff <= 1'b0;
               hit_ff    <= 1'b0;
               fired_ff  <= 1'b0;
               dfound_ff <= 1'b0;
               if (req_kind_type'(req_item.req_type) == REQ_TICK) begin
                  now_ff <= now_ff + 1'b1;
               end
            end
            OP_REG_FINISH: begin
               if (reg_ok) begin
                  valid_ff[free_idx] <= 1'b1;
                  armed_ff[free_idx] <= 1'b0;
                  util_ff            <= sum_new[UTIL_W-1:0];
               end
            end
            OP_YIELD_SCAN: begin
               idx_ff <= scan_last ? '0 : idx_ff + 1'b1;
               if (cur_match && !yfound_ff) begin
                  yfound_ff <= 1'b1;
               end
            end
            OP_YIELD_APPLY: begin
               if (yfound_ff && !missed) begin
                  armed_ff[yidx_ff] <= 1'b1;
                  if (grant_valid_ff && grant_slot_ff == yidx_ff) begin
                     grant_valid_ff <= 1'b0;
                  end
               end
            end
            OP_DEREG_SCAN: begin
               idx_ff <= scan_last ? '0 : idx_ff + 1'b1;
               if (cur_match) begin
                  hit_ff           <= 1'b1;
                  valid_ff[idx_ff] <= 1'b0;
                  armed_ff[idx_ff] <= 1'b0;
                  util_ff <= (util_ff >= UTIL_W'(term_ff[idx_ff]))
                             ? util_ff - UTIL_W'(term_ff[idx_ff]) : '0;
                  if (grant_valid_ff && grant_slot_ff == idx_ff) begin
                     grant_valid_ff <= 1'b0;
                  end
               end
            end
            OP_TICK_SCAN: begin
               idx_ff <= scan_last ? '0 : idx_ff + 1'b1;
               if (fire_now) begin
                  armed_ff[idx_ff] <= 1'b0;
                  fired_ff         <= 1'b1;
               end
            end
            OP_DISP_SCAN: begin
               idx_ff <= scan_last ? '0 : idx_ff + 1'b1;
               if (cand) begin
                  dfound_ff <= 1'b1;
               end
            end
            OP_DISP_APPLY: begin
               grant_valid_ff <= dfound_ff;
               if (dfound_ff) begin
                  grant_slot_ff <= best_ff;
               end
            end
            OP_RESPOND: begin
               rsp_valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (dp_cmd.op)
         OP_LOAD: begin
            req_ff    <= req_item;
            status_ff <= (req_kind_type'(req_item.req_type) == REQ_REGISTER
                          && req_item.period_ms == '0) ? RS_REJECT : RS_OK;
         end
         OP_REG_FINISH: begin
            if (over_limit) begin
               status_ff <= RS_REJECT;
            end else if (!free_found) begin
               status_ff <= RS_FULL;
            end else begin
               status_ff           <= RS_OK;
               pid_ff[free_idx]    <= req_ff.pid;
               period_ff[free_idx] <= req_ff.period_ms;
               term_ff[free_idx]   <= term;
               rs_ff[free_idx]     <= ST_SLEEP;
               last_ff[free_idx]   <= now_ff;
               wake_ff[free_idx]   <= '0;
            end
         end
         OP_YIELD_SCAN: begin
            if (cur_match && !yfound_ff) begin
               yidx_ff <= idx_ff;
            end
         end
         OP_YIELD_APPLY: begin
            if (!yfound_ff) begin
               status_ff <= RS_NOTFOUND;
            end else begin
               status_ff        <= missed ? RS_MISSED : RS_OK;
               last_ff[yidx_ff] <= next_time;
               if (!missed) begin
                  rs_ff[yidx_ff]   <= ST_SLEEP;
                  wake_ff[yidx_ff] <= next_time;
               end
            end
         end
         OP_DEREG_SCAN: begin
            if (scan_last) begin
               status_ff <= (hit_ff || cur_match) ? RS_OK : RS_NOTFOUND;
            end
         end
         OP_TICK_SCAN: begin
            if (fire_now) begin
               rs_ff[idx_ff] <= ST_READY;
            end
         end
         OP_DISP_SCAN: begin
            if (cand) begin
               best_ff        <= idx_ff;
               best_period_ff <= period_ff[idx_ff];
            end
         end
         OP_DISP_APPLY: begin
            if (grant_valid_ff && valid_ff[grant_slot_ff]
                && !(dfound_ff && best_ff == grant_slot_ff)) begin
               rs_ff[grant_slot_ff] <= (rs_ff[grant_slot_ff] == ST_RUN) ? ST_READY : ST_SLEEP;
            end
            if (dfound_ff) begin
               rs_ff[best_ff] <= ST_RUN;
            end
         end
         OP_RESPOND: begin
            rsp_item_ff.status          <= status_ff;
            rsp_item_ff.running_valid   <= grant_valid_ff;
            rsp_item_ff.running_pid     <= grant_valid_ff ? pid_ff[grant_slot_ff] : '0;
            rsp_item_ff.utilization_sum <= util_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign csr_ready = 1'b1;

endmodule
`default_nettype wire
